// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the sink responder.
// Simulation gets concurrent assertions; synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(label, clock, rst_n, prop) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, clock, rst_n, cond) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clock, rst_n, prop)
`define ASSERT_NEVER(label, clock, rst_n, cond)
`endif

`endif

// ===== hw/rtl/pdsc_pkg.sv =====
`timescale 1ns / 1ps
// Package of the sink responder: field widths, message and object codes.
// Used by pd_sink_source_cap_responder; depends on nothing.
package pdsc_pkg;

	localparam int WORD_W = 32;
	localparam int HDR_W  = 16;
	localparam int REG_W  = 10;
	localparam int CNT_W  = 3;
	localparam int REV_W  = 2;
	localparam int TYPE_W = 5;

	localparam logic [TYPE_W-1:0] PD_TYPE_GOODCRC = 5'd1;
	localparam logic [TYPE_W-1:0] PD_TYPE_SRC_CAP = 5'd1;
	localparam logic [TYPE_W-1:0] PD_TYPE_REQUEST = 5'd2;

	localparam logic [1:0] PDO_KIND_FIXED     = 2'd0;
	localparam logic [1:0] PDO_KIND_AUGMENTED = 2'd3;

	localparam logic CMD_HEADER = 1'b0;
	localparam logic CMD_OBJECT = 1'b1;

	localparam logic CFG_VOLTAGE_THRESHOLD = 1'b0;
	localparam logic CFG_REQUEST_CURRENT   = 1'b1;

	localparam logic [REG_W-1:0] VOLTAGE_THRESHOLD_RESET = 10'd400;
	localparam logic [REG_W-1:0] REQUEST_CURRENT_RESET   = 10'd10;

	function automatic logic [REG_W-1:0] pdo_max_voltage(input logic [WORD_W-1:0] pdo);
		if (pdo[31:30] == PDO_KIND_FIXED) begin
			return pdo[19:10];
		end
		return pdo[29:20];
	endfunction

endpackage

// ===== hw/rtl/pd_sink_source_cap_responder.sv =====
`timescale 1ns / 1ps
// Sink responder for USB Power Delivery: turns Source Capabilities into a Request.
// Depends on pdsc_pkg and assert_macros.svh.
//
// Usage:
// The input channel (in_valid/in_ready) carries one received word per transaction:
// cmd low for a message header, cmd high for one of its data objects. The output
// channel (out_valid/out_ready) carries the Request message, header word first
// (is_header high), then the request object (last high).
// A transaction is first captured in an input register; from there it updates the
// message state. A final Source Capabilities object loads the request header into
// the output register, and the object follows in the cycle after the header is
// taken. One input transaction is accepted per cycle unless in_ready drops; a request
// needs a header and an object word, so the output register sets the rate.
// When the receiver stalls with a request still pending, an item that would emit
// another request waits in the input register and in_ready drops; other items flow.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the user
// must make them only while the block is idle, which the block itself does not enforce.
// Reset clears the message counter, spec revision and scan state and restores the
// configuration defaults: threshold 400, current 10.
`include "assert_macros.svh"

module pd_sink_source_cap_responder import pdsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [REG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [WORD_W-1:0] data_word,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] tx_word,
	output logic              is_header,
	output logic              last
);

	logic [REG_W-1:0] voltage_threshold_q;
	logic [REG_W-1:0] request_current_q;

	logic              valid_s1;
	logic              cmd_s1;
	logic [WORD_W-1:0] word_s1;

	logic [CNT_W-1:0]  message_counter_q;
	logic [REV_W-1:0]  spec_revision_q;
	logic [TYPE_W-1:0] pending_type_q;
	logic [CNT_W-1:0]  objects_expected_q;
	logic [CNT_W-1:0]  objects_seen_q;
	logic [CNT_W-1:0]  chosen_position_q;
	logic              chosen_valid_q;

	logic              out_valid_q;
	logic              out_phase_q;
	logic [HDR_W-1:0]  hdr_q;
	logic [WORD_W-1:0] obj_q;

	logic [TYPE_W-1:0] hdr_type;
	logic [REV_W-1:0]  hdr_rev;
	logic [CNT_W-1:0]  hdr_count;
	logic [CNT_W-1:0]  obj_pos;
	logic              obj_in_range;
	logic              obj_pick;
	logic [CNT_W-1:0]  chosen_position_c;
	logic              chosen_valid_c;
	logic              emit;
	logic              out_free;
	logic              consume;

	assign hdr_type  = word_s1[4:0];
	assign hdr_rev   = word_s1[7:6];
	assign hdr_count = word_s1[14:12];

	assign obj_pos      = objects_seen_q + CNT_W'(1);
	assign obj_in_range = objects_seen_q < objects_expected_q;
	assign obj_pick     = (pending_type_q == PD_TYPE_SRC_CAP)
		&& (word_s1[31:30] != PDO_KIND_AUGMENTED)
		&& ((pdo_max_voltage(word_s1) >= voltage_threshold_q) || !chosen_valid_q);

	assign chosen_position_c = obj_pick ? obj_pos : chosen_position_q;
	assign chosen_valid_c    = obj_pick || chosen_valid_q;

	assign emit = valid_s1 && (cmd_s1 == CMD_OBJECT) && obj_in_range
		&& (pending_type_q == PD_TYPE_SRC_CAP) && (obj_pos == objects_expected_q)
		&& chosen_valid_c;

	assign out_free = !out_valid_q || (out_ready && out_phase_q);
	assign consume  = valid_s1 && (!emit || out_free);
	assign in_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voltage_threshold_q <= VOLTAGE_THRESHOLD_RESET;
			request_current_q   <= REQUEST_CURRENT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VOLTAGE_THRESHOLD: voltage_threshold_q <= cfg_data;
				CFG_REQUEST_CURRENT:   request_current_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= cmd;
			word_s1 <= data_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			message_counter_q  <= '0;
			spec_revision_q    <= '0;
			pending_type_q     <= '0;
			objects_expected_q <= '0;
			objects_seen_q     <= '0;
			chosen_position_q  <= '0;
			chosen_valid_q     <= 1'b0;
		end else if (consume) begin
			if (cmd_s1 == CMD_HEADER) begin
				pending_type_q     <= hdr_type;
				objects_expected_q <= hdr_count;
				objects_seen_q     <= '0;
				if (hdr_count == '0) begin
					if (hdr_type == PD_TYPE_GOODCRC) begin
						message_counter_q <= message_counter_q + CNT_W'(1);
					end
				end else if (hdr_type == PD_TYPE_SRC_CAP) begin
					spec_revision_q   <= hdr_rev;
					chosen_position_q <= '0;
					chosen_valid_q    <= 1'b0;
				end
			end else if (obj_in_range) begin
				objects_seen_q    <= obj_pos;
				chosen_position_q <= chosen_position_c;
				chosen_valid_q    <= chosen_valid_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_phase_q <= 1'b0;
		end else if (consume && emit) begin
			out_valid_q <= 1'b1;
			out_phase_q <= 1'b0;
		end else if (out_valid_q && out_ready) begin
			out_valid_q <= !out_phase_q;
			out_phase_q <= !out_phase_q;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && emit) begin
			hdr_q <= {1'b0, 3'b001, message_counter_q, 1'b0, spec_revision_q,
				1'b0, PD_TYPE_REQUEST};
			obj_q <= {1'b0, chosen_position_c, 3'b000, 1'b1, 4'b0000,
				request_current_q, request_current_q};
		end
	end

	assign out_valid = out_valid_q;
	assign tx_word   = out_phase_q ? obj_q : {{(WORD_W-HDR_W){1'b0}}, hdr_q};
	assign is_header = !out_phase_q;
	assign last      = out_phase_q;

	// The object word is only ever shown while a request is pending.
	`ASSERT_PROP(a_phase_needs_valid, clk, arst_n, out_phase_q |-> out_valid_q)
	// Taking the header must be followed by the request object.
	`ASSERT_PROP(a_header_then_object, clk, arst_n,
		(out_valid_q && out_ready && !out_phase_q) |=> (out_valid_q && out_phase_q))
	// The scan never counts more objects than the header announced.
	`ASSERT_PROP(a_seen_bounded, clk, arst_n, objects_seen_q <= objects_expected_q)
	// A chosen object has a one-based position.
	`ASSERT_PROP(a_chosen_position, clk, arst_n,
		chosen_valid_q |-> (chosen_position_q != '0))
	// A request must never overwrite one that is still pending.
	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, consume && emit && !out_free)

endmodule
